/* rtl/ltsan_pkg.sv */
package ltsan_pkg;

	localparam int CHAR_W = 8;
	localparam int CNT_W  = 2;
	localparam int IDX_W  = 3;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [IDX_W-1:0] {
		REG_REMOVE_DIACRITIC     = 3'd0,
		REG_REMOVE_PUNCTUATION   = 3'd1,
		REG_REMOVE_DUP_CHARS     = 3'd2,
		REG_REMOVE_BRACES        = 3'd3,
		REG_REMOVE_DOUBLE_QUOTES = 3'd4,
		REG_LOWER_CASE           = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic remove_diacritic;
		logic remove_punctuation;
		logic remove_dup_chars;
		logic remove_braces;
		logic remove_double_quotes;
		logic lower_case;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		remove_diacritic:     1'b1,
		remove_punctuation:   1'b1,
		remove_dup_chars:     1'b1,
		remove_braces:        1'b1,
		remove_double_quotes: 1'b0,
		lower_case:           1'b0
	};

	localparam cnt_t CNT_MAX = 2'd2;

	localparam char_t CH_A_UP  = 8'h41;
	localparam char_t CH_Z_UP  = 8'h5A;
	localparam char_t CH_A_LO  = 8'h61;
	localparam char_t CH_E_LO  = 8'h65;
	localparam char_t CH_I_LO  = 8'h69;
	localparam char_t CH_O_LO  = 8'h6F;
	localparam char_t CH_U_LO  = 8'h75;
	localparam char_t CH_E_UP  = 8'h45;
	localparam char_t CH_I_UP  = 8'h49;
	localparam char_t CH_O_UP  = 8'h4F;
	localparam char_t CH_U_UP  = 8'h55;
	localparam char_t CH_Z_LO  = 8'h7A;
	localparam char_t CH_R_LO  = 8'h72;
	localparam char_t CH_L_LO  = 8'h6C;
	localparam char_t CH_N_LO  = 8'h6E;
	localparam char_t CH_C_LO  = 8'h63;
	localparam char_t CH_COMMA = 8'h2C;
	localparam char_t CH_SEMI  = 8'h3B;
	localparam char_t CH_DOT   = 8'h2E;
	localparam char_t CH_EXCL  = 8'h21;
	localparam char_t CH_QUEST = 8'h3F;
	localparam char_t CH_IEXCL = 8'hA1;
	localparam char_t CH_IQUES = 8'hBF;
	localparam char_t CH_LBRACE = 8'h7B;
	localparam char_t CH_RBRACE = 8'h7D;
	localparam char_t CH_LBRACK = 8'h5B;
	localparam char_t CH_RBRACK = 8'h5D;
	localparam char_t CH_LPAREN = 8'h28;
	localparam char_t CH_RPAREN = 8'h29;
	localparam char_t CH_DQUOTE = 8'h22;
	localparam char_t CH_FEM_ORD  = 8'hAA;
	localparam char_t CH_MICRO    = 8'hB5;
	localparam char_t CH_MASC_ORD = 8'hBA;
	localparam char_t CH_UP_FIRST = 8'hC0;
	localparam char_t CH_UP_LAST  = 8'hDE;
	localparam char_t CH_TIMES    = 8'hD7;
	localparam char_t CH_DIVIDE   = 8'hF7;
	localparam char_t CASE_OFFSET = 8'h20;

	function automatic logic is_letter(input char_t c);
		is_letter = (c >= CH_A_UP && c <= CH_Z_UP) || (c >= CH_A_LO && c <= CH_Z_LO) ||
			c == CH_FEM_ORD || c == CH_MICRO || c == CH_MASC_ORD ||
			(c >= CH_UP_FIRST && c != CH_TIMES && c != CH_DIVIDE);
	endfunction

	function automatic char_t to_lower(input char_t c);
		if ((c >= CH_A_UP && c <= CH_Z_UP) ||
			(c >= CH_UP_FIRST && c <= CH_UP_LAST && c != CH_TIMES)) begin
			to_lower = c + CASE_OFFSET;
		end else begin
			to_lower = c;
		end
	endfunction

	function automatic char_t strip_accent(input char_t c);
		unique case (c)
			8'hE1:   strip_accent = CH_A_LO;
			8'hE9:   strip_accent = CH_E_LO;
			8'hED:   strip_accent = CH_I_LO;
			8'hF3:   strip_accent = CH_O_LO;
			8'hFA:   strip_accent = CH_U_LO;
			8'hFC:   strip_accent = CH_U_LO;
			8'hC1:   strip_accent = CH_A_UP;
			8'hC9:   strip_accent = CH_E_UP;
			8'hCD:   strip_accent = CH_I_UP;
			8'hD3:   strip_accent = CH_O_UP;
			8'hDA:   strip_accent = CH_U_UP;
			8'hDC:   strip_accent = CH_U_UP;
			default: strip_accent = c;
		endcase
	endfunction

	function automatic logic is_punct(input char_t c);
		is_punct = c == CH_COMMA || c == CH_SEMI || c == CH_DOT || c == CH_EXCL ||
			c == CH_QUEST || c == CH_IEXCL || c == CH_IQUES;
	endfunction

	function automatic logic is_brace(input char_t c);
		is_brace = c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACK ||
			c == CH_RBRACK || c == CH_LPAREN || c == CH_RPAREN;
	endfunction

	function automatic logic may_repeat(input char_t c);
		may_repeat = c == CH_R_LO || c == CH_L_LO || c == CH_N_LO ||
			c == CH_C_LO || c == CH_Z_LO;
	endfunction

endpackage

/* rtl/ltsan_cfg.sv */
module ltsan_cfg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [ltsan_pkg::IDX_W-1:0] cfg_index,
	input  logic                   cfg_data,
	output ltsan_pkg::cfg_t        cfg
);

	ltsan_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ltsan_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			unique case (ltsan_pkg::cfg_index_t'(cfg_index))
				ltsan_pkg::REG_REMOVE_DIACRITIC:     cfg_q.remove_diacritic     <= cfg_data;
				ltsan_pkg::REG_REMOVE_PUNCTUATION:   cfg_q.remove_punctuation   <= cfg_data;
				ltsan_pkg::REG_REMOVE_DUP_CHARS:     cfg_q.remove_dup_chars     <= cfg_data;
				ltsan_pkg::REG_REMOVE_BRACES:        cfg_q.remove_braces        <= cfg_data;
				ltsan_pkg::REG_REMOVE_DOUBLE_QUOTES: cfg_q.remove_double_quotes <= cfg_data;
				ltsan_pkg::REG_LOWER_CASE:           cfg_q.lower_case           <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

/* rtl/ltsan_filter.sv */
module ltsan_filter (
	input  ltsan_pkg::cfg_t  cfg,
	input  ltsan_pkg::char_t char_cur,
	input  logic             first,
	input  ltsan_pkg::char_t prev_char,
	input  ltsan_pkg::cnt_t  count,
	output ltsan_pkg::cnt_t  count_next,
	output logic             keep,
	output ltsan_pkg::char_t char_res
);

	logic             match;
	ltsan_pkg::cnt_t  run_cnt;
	logic             dup_drop;
	ltsan_pkg::char_t plain;

	always_comb begin
		match = ltsan_pkg::is_letter(char_cur) &&
			ltsan_pkg::to_lower(char_cur) == ltsan_pkg::to_lower(prev_char);
		if (!match) begin
			run_cnt = '0;
		end else if (count < ltsan_pkg::CNT_MAX) begin
			run_cnt = count + ltsan_pkg::cnt_t'(1);
		end else begin
			run_cnt = count;
		end

		// string start clears the run; a disabled stage holds it
		priority if (first) begin
			count_next = '0;
			dup_drop   = 1'b0;
		end else if (cfg.remove_dup_chars) begin
			count_next = run_cnt;
			dup_drop   = !(run_cnt == '0 ||
				(run_cnt == ltsan_pkg::cnt_t'(1) && ltsan_pkg::may_repeat(char_cur)));
		end else begin
			count_next = count;
			dup_drop   = 1'b0;
		end

		plain = cfg.remove_diacritic ? ltsan_pkg::strip_accent(char_cur) : char_cur;

		keep = !dup_drop &&
			!(cfg.remove_punctuation && ltsan_pkg::is_punct(char_cur)) &&
			!(cfg.remove_braces && ltsan_pkg::is_brace(plain)) &&
			!(cfg.remove_double_quotes && plain == ltsan_pkg::CH_DQUOTE);

		char_res = cfg.lower_case ? ltsan_pkg::to_lower(plain) : plain;
	end

endmodule

/* rtl/latin1_text_sanitizer_core.sv */
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+-------------------------
// input    | in        | in_valid / in_ready   | char_in, starts_string
// output   | out       | out_valid / out_ready | char_out
// config   | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One character per cycle while the output is not stalled: an input register
// feeds the filter logic, whose result lands in an output register.
// The running state (previous character, repeat count) advances when an item
// leaves the input register; dropped characters produce no output transfer.
// Reset clears the state and loads the default filter enables.
// A stalled output holds the output register and a full input register; cfg_ready is always high.
module latin1_text_sanitizer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ltsan_pkg::CHAR_W-1:0] char_in,
	input  logic                         starts_string,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ltsan_pkg::CHAR_W-1:0] char_out,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ltsan_pkg::IDX_W-1:0]  cfg_index,
	input  logic                         cfg_data
);

	ltsan_pkg::cfg_t  cfg;
	ltsan_pkg::char_t char_s1;
	logic             starts_s1;
	logic             valid_s1;
	ltsan_pkg::char_t prev_char_q;
	ltsan_pkg::cnt_t  count_q;
	ltsan_pkg::cnt_t  count_next;
	logic             keep;
	ltsan_pkg::char_t char_res;
	ltsan_pkg::char_t out_char_q;
	logic             out_valid_q;
	logic             advance;

	ltsan_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ltsan_filter u_filter (
		.cfg        (cfg),
		.char_cur   (char_s1),
		.first      (starts_s1),
		.prev_char  (prev_char_q),
		.count      (count_q),
		.count_next (count_next),
		.keep       (keep),
		.char_res   (char_res)
	);

	// the output register is free or is being emptied this cycle
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			prev_char_q <= '0;
			count_q     <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1 && keep;
			end
			if (valid_s1 && advance) begin
				prev_char_q <= char_s1;
				count_q     <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1   <= char_in;
			starts_s1 <= starts_string;
		end
		if (advance && valid_s1) begin
			out_char_q <= char_res;
		end
	end

	assign out_valid = out_valid_q;
	assign char_out  = out_char_q;

endmodule

/* tb/sv/latin1_text_sanitizer_core_tb.sv */
`timescale 1ns / 100ps

module latin1_text_sanitizer_core_tb;

	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES  = 80;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 50;

	// Running copy of the filter: enables, last raw character, repeat run length.
	class sanitized_char_board;
		ltsan_pkg::cfg_t  enables;
		ltsan_pkg::char_t last_raw;
		ltsan_pkg::cnt_t  run_len;
		ltsan_pkg::char_t expected_chars[$];
		int    errors;
		int    chars_in;
		int    chars_out;
		int    chars_dropped;

		function new();
			enables       = ltsan_pkg::CFG_RESET;
			last_raw      = '0;
			run_len       = '0;
			errors        = 0;
			chars_in      = 0;
			chars_out     = 0;
			chars_dropped = 0;
		endfunction

		function bit letter_p(ltsan_pkg::char_t c);
			return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'hAA, 8'hB5, 8'hBA}) ||
				(c >= 8'hC0 && c != 8'hD7 && c != 8'hF7);
		endfunction

		function ltsan_pkg::char_t fold_case(ltsan_pkg::char_t c);
			if ((c inside {[8'h41:8'h5A]}) || ((c inside {[8'hC0:8'hDE]}) && c != 8'hD7))
				return c + 8'h20;
			return c;
		endfunction

		function ltsan_pkg::char_t plain_vowel(ltsan_pkg::char_t c);
			case (c)
				8'hE1: return "a";
				8'hE9: return "e";
				8'hED: return "i";
				8'hF3: return "o";
				8'hFA, 8'hFC: return "u";
				8'hC1: return "A";
				8'hC9: return "E";
				8'hCD: return "I";
				8'hD3: return "O";
				8'hDA, 8'hDC: return "U";
				default: return c;
			endcase
		endfunction

		function void write_enable(ltsan_pkg::cfg_index_t idx, logic v);
			case (idx)
				ltsan_pkg::REG_REMOVE_DIACRITIC:     enables.remove_diacritic     = v;
				ltsan_pkg::REG_REMOVE_PUNCTUATION:   enables.remove_punctuation   = v;
				ltsan_pkg::REG_REMOVE_DUP_CHARS:     enables.remove_dup_chars     = v;
				ltsan_pkg::REG_REMOVE_BRACES:        enables.remove_braces        = v;
				ltsan_pkg::REG_REMOVE_DOUBLE_QUOTES: enables.remove_double_quotes = v;
				ltsan_pkg::REG_LOWER_CASE:           enables.lower_case           = v;
				default: ;
			endcase
		endfunction

		// Returns 1 and the filtered character when the character survives.
		function bit filter_char(ltsan_pkg::char_t raw, logic first,
			output ltsan_pkg::char_t kept);
			ltsan_pkg::char_t prev;
			ltsan_pkg::char_t cur;
			prev     = last_raw;
			cur      = raw;
			last_raw = raw;
			kept     = '0;
			if (first)
				run_len = '0;
			if (enables.remove_dup_chars && !first) begin
				if (letter_p(cur) && fold_case(cur) == fold_case(prev)) begin
					if (run_len < ltsan_pkg::CNT_MAX)
						run_len = run_len + 1'b1;
				end else begin
					run_len = '0;
				end
				if (!(run_len == 0 ||
					(run_len == 1 && (cur inside {"r", "l", "n", "c", "z"}))))
					return 0;
			end
			if (enables.remove_punctuation &&
				(cur inside {",", ";", ".", "!", "?", 8'hA1, 8'hBF}))
				return 0;
			if (enables.remove_diacritic)
				cur = plain_vowel(cur);
			if (enables.remove_braces && (cur inside {"{", "}", "[", "]", "(", ")"}))
				return 0;
			if (enables.remove_double_quotes && cur == "\"")
				return 0;
			if (enables.lower_case)
				cur = fold_case(cur);
			kept = cur;
			return 1;
		endfunction

		function void note_char(ltsan_pkg::char_t raw, logic first);
			ltsan_pkg::char_t kept;
			chars_in++;
			if (filter_char(raw, first, kept))
				expected_chars.push_back(kept);
			else
				chars_dropped++;
		endfunction

		function void check_char(ltsan_pkg::char_t got);
			ltsan_pkg::char_t want;
			chars_out++;
			if (expected_chars.size() == 0) begin
				$error("char_out: expected none, actual %02h", got);
				errors++;
				return;
			end
			want = expected_chars.pop_front();
			if (got !== want) begin
				$error("char_out: expected %02h, actual %02h", want, got);
				errors++;
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [ltsan_pkg::CHAR_W-1:0] char_in;
	logic                         starts_string;
	logic                         out_valid;
	logic                         out_ready;
	logic [ltsan_pkg::CHAR_W-1:0] char_out;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [ltsan_pkg::IDX_W-1:0]  cfg_index;
	logic                         cfg_data;

	sanitized_char_board board;
	bit    quiet;
	bit    hold_req;
	int    idle_cycles;
	int    settings_used;
	ltsan_pkg::char_t last_sent;

	latin1_text_sanitizer_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_in       (char_in),
		.starts_string (starts_string),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.char_out      (char_out),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_char(char_in, starts_string);
			if (out_valid && out_ready)
				board.check_char(char_out);
			if (cfg_valid && cfg_ready)
				board.write_enable(ltsan_pkg::cfg_index_t'(cfg_index), cfg_data);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: random stalls, one long hold-off on request, none when quiet.
	initial begin
		out_ready <= 1'b0;
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (quiet) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
	end

	task automatic send_char(input ltsan_pkg::char_t c, input logic first);
		char_in       <= c;
		starts_string <= first;
		in_valid      <= 1'b1;
		last_sent      = c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic input_gap();
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input ltsan_pkg::cfg_index_t idx, input logic v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic program_filters(input ltsan_pkg::cfg_t c);
		write_reg(ltsan_pkg::REG_REMOVE_DIACRITIC,     c.remove_diacritic);
		write_reg(ltsan_pkg::REG_REMOVE_PUNCTUATION,   c.remove_punctuation);
		write_reg(ltsan_pkg::REG_REMOVE_DUP_CHARS,     c.remove_dup_chars);
		write_reg(ltsan_pkg::REG_REMOVE_BRACES,        c.remove_braces);
		write_reg(ltsan_pkg::REG_REMOVE_DOUBLE_QUOTES, c.remove_double_quotes);
		write_reg(ltsan_pkg::REG_LOWER_CASE,           c.lower_case);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Wait for every expected character, then let dropped ones clear the pipe.
	task automatic settle_pipeline();
		do
			@(posedge clk);
		while (board.expected_chars.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly runs of near-duplicate letters and filter targets, some raw noise.
	task automatic pick_char(output ltsan_pkg::char_t c, output logic first);
		ltsan_pkg::char_t specials[] = '{",", ";", ".", "!", "?", 8'hA1, 8'hBF,
			"{", "}", "[", "]", "(", ")", "\"", 8'hE1, 8'hE9, 8'hED, 8'hF3, 8'hFA,
			8'hFC, 8'hC1, 8'hC9, 8'hCD, 8'hD3, 8'hDA, 8'hDC, 8'hD7, 8'hF7, 8'hAA,
			8'hB5, 8'hBA, 8'hFF};
		ltsan_pkg::char_t doubles[] = '{"r", "l", "n", "c", "z", "R", "L", "N", "C",
			"Z", "a", "e"};
		int    roll;
		roll  = $urandom_range(0, 99);
		first = ($urandom_range(0, 9) == 0);
		if (roll < 35)
			c = last_sent ^ (($urandom_range(0, 2) == 0) ? 8'h20 : 8'h00);
		else if (roll < 55)
			c = specials[$urandom_range(0, specials.size() - 1)];
		else if (roll < 70)
			c = doubles[$urandom_range(0, doubles.size() - 1)];
		else if (roll < 85)
			c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) +
				ltsan_pkg::char_t'($urandom_range(0, 25));
		else
			c = ltsan_pkg::char_t'($urandom_range(0, 255));
	endtask

	initial begin
		ltsan_pkg::char_t c;
		logic             first;
		logic [5:0]       bits;
		ltsan_pkg::cfg_t  setting;

		board          = new();
		quiet          = 1'b0;
		hold_req       = 1'b0;
		settings_used  = 0;
		idle_cycles    = 0;
		last_sent      = '0;
		arst_n         = 1'b0;
		in_valid      <= 1'b0;
		char_in       <= '0;
		starts_string <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= ltsan_pkg::REG_REMOVE_DIACRITIC;
		cfg_data      <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass under the reset enables.
		send_char(8'h00, 1'b0);   // first character after reset, no string start
		send_char(8'hFF, 1'b0);
		send_char("r", 1'b1);
		send_char("r", 1'b0);     // allowed single repeat
		send_char("r", 1'b0);     // second repeat drops
		send_char("R", 1'b0);     // case-folded match, count saturates
		send_char("A", 1'b1);
		send_char("a", 1'b0);     // repeat of a letter that may not repeat
		send_char("x", 1'b0);
		send_char("x", 1'b1);     // string start clears the run
		send_char(",", 1'b0);
		send_char(8'hA1, 1'b0);
		send_char(8'hBF, 1'b0);
		send_char("?", 1'b0);
		send_char(8'hE1, 1'b0);
		send_char(8'hDC, 1'b0);
		send_char("(", 1'b0);
		send_char("\"", 1'b0);
		send_char(8'hD7, 1'b0);   // non-letters never count as repeats
		send_char(8'hD7, 1'b0);
		send_char(8'hC0, 1'b0);
		send_char(8'hE0, 1'b0);   // Latin-1 case pair
		send_char(8'hB5, 1'b0);
		send_char(8'hB5, 1'b0);
		send_char("z", 1'b0);
		send_char("z", 1'b0);
		in_valid <= 1'b0;
		settle_pipeline();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				setting = '1;
			end else if (p == 1) begin
				setting = '0;
			end else begin
				bits    = 6'($urandom_range(0, 63));
				setting = bits;
			end
			program_filters(setting);
			if (p == PHASES - 1)
				quiet = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == 5)
					hold_req = 1'b1;
				if (p == 3 && i == 25) begin
					in_valid <= 1'b0;
					settle_pipeline();
				end else begin
					input_gap();
				end
				pick_char(c, first);
				send_char(c, first);
			end
			in_valid <= 1'b0;
			settle_pipeline();
		end

		if (board.expected_chars.size() != 0) begin
			$error("char_out: expected %0d more, actual none", board.expected_chars.size());
			board.errors++;
		end
		$display("Run: %0d characters over %0d filter settings, %0d checked, %0d dropped",
			board.chars_in, settings_used, board.chars_out, board.chars_dropped);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
rtl/ltsan_pkg.sv
rtl/ltsan_cfg.sv
rtl/ltsan_filter.sv
rtl/latin1_text_sanitizer_core.sv
tb/sv/latin1_text_sanitizer_core_tb.sv
